### src/superframe_index_parser_assert.svh
// ============================================================================
// Superframe index parser assertion macros
// Shared assertion forms, clocked on the rising edge and disabled in reset.
// ============================================================================
`ifndef SUPERFRAME_INDEX_PARSER_ASSERT_SVH
`define SUPERFRAME_INDEX_PARSER_ASSERT_SVH

// Same-cycle implication.
`define SFIP_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SFIP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/sfip_pkg.sv
// ============================================================================
// sfip_pkg
// Types, constants and marker decode functions of the superframe index parser.
// ============================================================================
package sfip_pkg;

    localparam int WINDOW_DEPTH = 34;
    localparam int SEEN_W       = 6;
    localparam int PTR_W        = 6;
    localparam int RAM_DEPTH    = 2 ** PTR_W;
    localparam int QUEUE_DEPTH  = 2;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 40;
    localparam int M_TUSER_W    = 2;

    localparam logic [7:0] MARKER_MASK = 8'he0;
    localparam logic [7:0] MARKER_TAG  = 8'hc0;
    localparam logic [2:0] COUNT_MASK  = 3'h7;
    localparam logic [1:0] WIDTH_MASK  = 2'h3;

    typedef enum logic [1:0] {
        ST_NO_INDEX = 2'd0,
        ST_ENTRY    = 2'd1,
        ST_CORRUPT  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        JOB_NO_INDEX,
        JOB_CORRUPT,
        JOB_INDEX
    } job_kind_t;

    typedef struct packed {
        job_kind_t        kind;
        logic [7:0]       marker;
        logic [PTR_W-1:0] end_ptr;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_OPEN_RD,
        BK_OPEN_CHK,
        BK_SIZE_RD,
        BK_SIZE_CAP,
        BK_EMIT
    } back_state_t;

    function automatic logic marker_ok(input logic [7:0] marker);
        marker_ok = (marker & MARKER_MASK) == MARKER_TAG;
    endfunction

    // Frame count minus one.
    function automatic logic [2:0] frames_m1(input logic [7:0] marker);
        frames_m1 = marker[2:0] & COUNT_MASK;
    endfunction

    // Size width in bytes minus one.
    function automatic logic [1:0] mag_m1(input logic [7:0] marker);
        mag_m1 = marker[4:3] & WIDTH_MASK;
    endfunction

    // Index length: two marker bytes plus all size bytes, at most 34.
    function automatic logic [SEEN_W-1:0] index_size(input logic [7:0] marker);
        logic [SEEN_W-1:0] mag;
        logic [SEEN_W-1:0] frames;
        logic [SEEN_W-1:0] prod;
        mag        = SEEN_W'(mag_m1(marker)) + SEEN_W'(1);
        frames     = SEEN_W'(frames_m1(marker)) + SEEN_W'(1);
        prod       = SEEN_W'(mag * frames);
        index_size = prod + SEEN_W'(2);
    endfunction

endpackage

### src/superframe_index_parser.sv
// ============================================================================
// superframe_index_parser
// Finds the superframe index at the tail of a chunk and streams its sizes.
// ============================================================================
//
// Channel   Dir  Item contents (tdata from bit 0 up; tuser; tlast)
// s_        in   data_byte[7:0]; tlast = chunk_end
// m_        out  entry_size[31:0], frame_number[34:32], frame_total[38:35],
//                zero fill; tuser = status[1:0]; tlast = run_last
//
// Bytes are taken one per cycle into a 64-entry window ring; a full two-entry
// job queue, or an index still being read from the ring, holds the input off.
// A result without index entries goes from idle straight to the output. For
// an index, the back reads and checks the opening marker (a mismatch gives a
// corrupt result), then one RAM read per size byte and one result per frame.
// Reset is synchronous and active low; the ring is not cleared.
// ============================================================================
module superframe_index_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [sfip_pkg::S_TDATA_W-1:0] s_tdata,  // data_byte[7:0]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // entry_size[31:0], frame_number[34:32], frame_total[38:35]
    output logic [sfip_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [sfip_pkg::M_TUSER_W-1:0] m_tuser,  // status[1:0]
    output logic        m_tlast
);
    import sfip_pkg::*;

    logic             ram_wr_en;
    logic [PTR_W-1:0] ram_wr_addr;
    logic [7:0]       ram_wr_data;
    logic             ram_rd_en;
    logic [PTR_W-1:0] ram_rd_addr;
    logic [7:0]       ram_rd_data;
    logic             q_push, q_full, q_pop, q_empty;
    job_t             q_job, head_job;
    logic             idx_done;

    // The front stores each byte and, on the final byte, queues one job that
    // says whether an index is absent, corrupt by length, or to be read.
    sfip_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .q_push      (q_push),
        .q_job       (q_job),
        .q_full      (q_full),
        .idx_done    (idx_done)
    );

    sfip_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_job),
        .full     (q_full),
        .pop      (q_pop),
        .head_job (head_job),
        .empty    (q_empty)
    );

    // The ring is larger than the 34-byte window so that a free-running
    // pointer wraps on its own.
    sfip_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The back checks the opening marker, reads the sizes little-endian and
    // owns the output register.
    sfip_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_job    (head_job),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .idx_done    (idx_done),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

### src/sfip_ram.sv
// ============================================================================
// sfip_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module sfip_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/sfip_front.sv
// ============================================================================
// sfip_front
// Takes chunk bytes, stores them in the window ring and classifies chunk ends.
// ============================================================================
module sfip_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [sfip_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                      s_tlast,
    output logic                      ram_wr_en,
    output logic [sfip_pkg::PTR_W-1:0] ram_wr_addr,
    output logic [7:0]                ram_wr_data,
    output logic                      q_push,
    output sfip_pkg::job_t            q_job,
    input  logic                      q_full,
    input  logic                      idx_done
);
    import sfip_pkg::*;

    logic [SEEN_W-1:0] seen_reg, seen_next, seen_inc;
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic              pending_reg, pending_next;
    logic              accept;
    logic [7:0]        byte_in;

    // The ring must not be overwritten while an index is still being read.
    assign s_tready = !q_full && !pending_reg;
    assign accept   = s_tvalid && s_tready;
    assign byte_in  = s_tdata[7:0];

    assign ram_wr_en   = accept;
    assign ram_wr_addr = wr_ptr_reg;
    assign ram_wr_data = byte_in;

    always_comb begin
        seen_inc     = (seen_reg < SEEN_W'(WINDOW_DEPTH)) ? seen_reg + SEEN_W'(1) : seen_reg;
        seen_next    = seen_reg;
        wr_ptr_next  = wr_ptr_reg;
        pending_next = pending_reg;
        q_push       = 1'b0;
        q_job.marker  = byte_in;
        q_job.end_ptr = wr_ptr_reg;
        if (!marker_ok(byte_in)) begin
            q_job.kind = JOB_NO_INDEX;
        end else if (seen_inc < index_size(byte_in)) begin
            q_job.kind = JOB_CORRUPT;
        end else begin
            q_job.kind = JOB_INDEX;
        end
        if (idx_done) begin
            pending_next = 1'b0;
        end
        if (accept) begin
            wr_ptr_next = wr_ptr_reg + PTR_W'(1);
            seen_next   = s_tlast ? '0 : seen_inc;
            if (s_tlast) begin
                q_push = 1'b1;
                if (q_job.kind == JOB_INDEX) begin
                    pending_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            wr_ptr_reg  <= '0;
            pending_reg <= 1'b0;
        end else begin
            seen_reg    <= seen_next;
            wr_ptr_reg  <= wr_ptr_next;
            pending_reg <= pending_next;
        end
    end

endmodule

### src/sfip_queue.sv
// ============================================================================
// sfip_queue
// Short job queue between the front and the back.
// ============================================================================
module sfip_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  sfip_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output sfip_pkg::job_t head_job,
    output logic           empty
);
    import sfip_pkg::*;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t              entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full     = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_job = entries[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries[wr_ptr_reg] <= push_job;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### src/sfip_back.sv
// ============================================================================
// sfip_back
// Checks the opening marker, gathers frame sizes and drives the result stream.
// ============================================================================
`include "superframe_index_parser_assert.svh"

module sfip_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  sfip_pkg::job_t             head_job,
    input  logic                       q_empty,
    output logic                       q_pop,
    output logic                       ram_rd_en,
    output logic [sfip_pkg::PTR_W-1:0] ram_rd_addr,
    input  logic [7:0]                 ram_rd_data,
    output logic                       idx_done,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [sfip_pkg::M_TDATA_W-1:0] m_tdata,
    output logic [sfip_pkg::M_TUSER_W-1:0] m_tuser,
    output logic                       m_tlast
);
    import sfip_pkg::*;

    back_state_t       state_reg, state_next;
    logic [7:0]        marker_reg, marker_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [1:0]        byte_idx_reg, byte_idx_next;
    logic [2:0]        frame_idx_reg, frame_idx_next;
    logic [31:0]       size_reg, size_next;
    status_t           status_reg, status_next;

    logic              m_valid_reg, m_valid_next;
    status_t           m_status_reg;
    logic [31:0]       m_size_reg;
    logic [2:0]        m_number_reg;
    logic [3:0]        m_total_reg;
    logic              m_last_reg;

    logic              out_free, load, res_last, open_ok, size_done;
    logic [3:0]        res_total;

    assign out_free  = !m_valid_reg || m_tready;
    assign res_last  = (status_reg != ST_ENTRY) || (frame_idx_reg == frames_m1(marker_reg));
    assign res_total = (status_reg == ST_ENTRY) ? {1'b0, frames_m1(marker_reg)} + 4'd1 : 4'd0;
    assign open_ok   = ram_rd_data == marker_reg;
    assign size_done = byte_idx_reg == mag_m1(marker_reg);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    state_next = (head_job.kind == JOB_INDEX) ? BK_OPEN_RD : BK_EMIT;
                end
            end
            BK_OPEN_RD:  state_next = BK_OPEN_CHK;
            BK_OPEN_CHK: state_next = open_ok ? BK_SIZE_RD : BK_EMIT;
            BK_SIZE_RD:  state_next = BK_SIZE_CAP;
            BK_SIZE_CAP: state_next = size_done ? BK_EMIT : BK_SIZE_RD;
            BK_EMIT: begin
                if (out_free) begin
                    state_next = res_last ? BK_IDLE : BK_SIZE_RD;
                end
            end
            default:     state_next = BK_IDLE;
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        q_pop          = 1'b0;
        ram_rd_en      = 1'b0;
        idx_done       = 1'b0;
        load           = 1'b0;
        marker_next    = marker_reg;
        rd_ptr_next    = rd_ptr_reg;
        byte_idx_next  = byte_idx_reg;
        frame_idx_next = frame_idx_reg;
        size_next      = size_reg;
        status_next    = status_reg;
        case (state_reg)
            BK_IDLE: begin
                q_pop          = !q_empty;
                marker_next    = head_job.marker;
                // The opening marker sits index_size - 1 bytes behind the final byte.
                rd_ptr_next    = head_job.end_ptr
                               - PTR_W'(index_size(head_job.marker) - SEEN_W'(1));
                frame_idx_next = '0;
                byte_idx_next  = '0;
                size_next      = '0;
                case (head_job.kind)
                    JOB_NO_INDEX: status_next = ST_NO_INDEX;
                    JOB_CORRUPT:  status_next = ST_CORRUPT;
                    JOB_INDEX:    status_next = ST_ENTRY;
                    default:      status_next = ST_NO_INDEX;
                endcase
            end
            BK_OPEN_RD: begin
                ram_rd_en   = 1'b1;
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            end
            BK_OPEN_CHK: begin
                if (!open_ok) begin
                    idx_done    = 1'b1;
                    status_next = ST_CORRUPT;
                end
            end
            BK_SIZE_RD: begin
                ram_rd_en   = 1'b1;
                rd_ptr_next = rd_ptr_reg + PTR_W'(1);
            end
            BK_SIZE_CAP: begin
                case (byte_idx_reg)
                    2'd0:    size_next[7:0]   = ram_rd_data;
                    2'd1:    size_next[15:8]  = ram_rd_data;
                    2'd2:    size_next[23:16] = ram_rd_data;
                    default: size_next[31:24] = ram_rd_data;
                endcase
                byte_idx_next = byte_idx_reg + 2'd1;
                // The last size byte of the index has been read from the window.
                idx_done = size_done && (frame_idx_reg == frames_m1(marker_reg));
            end
            BK_EMIT: begin
                load = out_free;
                if (out_free && !res_last) begin
                    frame_idx_next = frame_idx_reg + 3'd1;
                    byte_idx_next  = '0;
                    size_next      = '0;
                end
            end
            default: begin
            end
        endcase
        m_valid_next = load ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        marker_reg    <= marker_next;
        rd_ptr_reg    <= rd_ptr_next;
        byte_idx_reg  <= byte_idx_next;
        frame_idx_reg <= frame_idx_next;
        size_reg      <= size_next;
        status_reg    <= status_next;
        if (load) begin
            m_status_reg <= status_reg;
            m_size_reg   <= size_reg;
            m_number_reg <= frame_idx_reg;
            m_total_reg  <= res_total;
            m_last_reg   <= res_last;
        end
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign ram_rd_addr = rd_ptr_reg;
    assign m_tvalid    = m_valid_reg;
    assign m_tlast     = m_last_reg;
    assign m_tuser     = m_status_reg;
    assign m_tdata     = {1'b0, m_total_reg, m_number_reg, m_size_reg};

    `SFIP_ASSERT_NOW(a_entry_number, aclk, aresetn,
        m_valid_reg && (m_status_reg == ST_ENTRY),
        ({1'b0, m_number_reg} < m_total_reg), "frame number beyond frame total")
    `SFIP_ASSERT_NOW(a_status_single, aclk, aresetn,
        m_valid_reg && (m_status_reg != ST_ENTRY),
        m_last_reg && (m_total_reg == 4'd0), "status result not alone")
    `SFIP_ASSERT_NOW(a_done_place, aclk, aresetn, idx_done,
        (state_reg == BK_OPEN_CHK) || (state_reg == BK_SIZE_CAP),
        "index release outside a window read")
    `SFIP_ASSERT_NEXT(a_pop_starts, aclk, aresetn, q_pop,
        state_reg != BK_IDLE, "job taken but back part stayed idle")

endmodule

### verif/tb_superframe_index_parser.sv
// ============================================================================
// tb_superframe_index_parser
// Self-checking bench for the superframe index parser. Chunks of bytes are
// streamed in, and every index entry or status that comes out is compared
// against a predicted copy built from the same accepted bytes.
// ============================================================================
module tb_superframe_index_parser;

    timeunit 1ns;
    timeprecision 1ps;

    import sfip_pkg::*;

    localparam int ITEM_COUNT   = 470;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 400;

    // One predicted result item, split into its fields.
    typedef struct {
        status_t     status;
        logic [31:0] size;
        logic [2:0]  number;
        logic [3:0]  total;
        logic        last;
    } index_entry_t;

    // The scoreboard keeps its own byte window and chunk length, turns each
    // accepted byte into the entries it causes, and checks the output side
    // against the oldest entry still waiting.
    class index_scoreboard;
        index_entry_t      expected_entries[$];
        logic [7:0]        window[WINDOW_DEPTH];
        logic [SEEN_W-1:0] seen_count;
        int                mismatches;

        function new();
            foreach (window[i]) window[i] = 8'h00;
            seen_count = '0;
            mismatches = 0;
        endfunction

        function void add_entry(status_t st, logic [31:0] size, logic [2:0] number,
                                logic [3:0] total, logic last);
            index_entry_t e;
            e.status = st;
            e.size   = size;
            e.number = number;
            e.total  = total;
            e.last   = last;
            expected_entries.push_back(e);
        endfunction

        // Called once for every byte accepted on the input side.
        function void take_byte(logic [7:0] b, logic chunk_end);
            int          seen;
            int          frames;
            int          width;
            int          index_len;
            int          base;
            logic [31:0] size;
            for (int i = WINDOW_DEPTH - 1; i > 0; i--) window[i] = window[i - 1];
            window[0] = b;
            if (seen_count < WINDOW_DEPTH) seen_count++;
            if (!chunk_end) return;
            seen       = int'(seen_count);
            seen_count = '0;
            if ((b & MARKER_MASK) != MARKER_TAG) begin
                add_entry(ST_NO_INDEX, 32'd0, 3'd0, 4'd0, 1'b1);
                return;
            end
            frames    = int'(b[2:0]) + 1;
            width     = int'(b[4:3]) + 1;
            index_len = 2 + width * frames;
            // The opening marker must sit at the far end of the index, inside
            // the bytes of this chunk.
            if (seen < index_len || window[index_len - 1] != b) begin
                add_entry(ST_CORRUPT, 32'd0, 3'd0, 4'd0, 1'b1);
                return;
            end
            base = index_len - 2;
            for (int f = 0; f < frames; f++) begin
                size = 32'd0;
                for (int k = 0; k < width; k++)
                    size |= 32'(window[base - (f * width + k)]) << (8 * k);
                add_entry(ST_ENTRY, size, 3'(f), 4'(frames), f == frames - 1);
            end
        endfunction

        task report_mismatch(string what, longint got, longint want);
            $display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
            mismatches++;
        endtask

        task check_entry(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user,
                         logic last);
            index_entry_t want;
            if (expected_entries.size() == 0) begin
                report_mismatch("unexpected result item", longint'(data), 0);
                return;
            end
            want = expected_entries.pop_front();
            if (user !== want.status)
                report_mismatch("status", user, want.status);
            if (data[31:0] !== want.size)
                report_mismatch("entry_size", data[31:0], want.size);
            if (data[34:32] !== want.number)
                report_mismatch("frame_number", data[34:32], want.number);
            if (data[38:35] !== want.total)
                report_mismatch("frame_total", data[38:35], want.total);
            if (last !== want.last)
                report_mismatch("run_last", last, want.last);
        endtask

        function int pending();
            return expected_entries.size();
        endfunction

        task flag_leftovers();
            if (expected_entries.size() != 0)
                report_mismatch("result items never delivered",
                                expected_entries.size(), 0);
        endtask
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // data_byte[7:0]
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // entry_size[31:0], frame_number[34:32], frame_total[38:35]
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;         // status[1:0]
    logic                 m_tlast;

    index_scoreboard sb = new();

    // Bytes of the chunk being assembled, and sender bookkeeping.
    logic [7:0] chunk_q[$];
    int         items_sent  = 0;
    int         burst_left  = 0;
    int         cycle_count = 0;

    // Set by the stimulus once; the receiver then holds off for a long stretch.
    logic       hold_off_req = 1'b0;

    superframe_index_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Offer one item and wait until it is taken. The sender runs in bursts:
    // when a burst is used up, it may drop valid for a random gap before the
    // next item, and some bursts start without any gap at all.
    task automatic send_byte(input logic [7:0] b, input logic chunk_end);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= chunk_end;
        do @(posedge aclk); while (!s_tready);
        sb.take_byte(b, chunk_end);
        items_sent++;
    endtask

    // Sends the assembled chunk with the last byte flagged, then empties it.
    task automatic send_chunk();
        for (int i = 0; i < chunk_q.size(); i++)
            send_byte(chunk_q[i], i == chunk_q.size() - 1);
        chunk_q.delete();
    endtask

    // Size bytes lean on the all-zero and all-one patterns now and then.
    function automatic logic [7:0] random_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Builds one random chunk. Most are well-formed indexes with random
    // content behind a random lead-in; the rest have a damaged opening marker,
    // are cut short, carry no marker, or are plain noise.
    task automatic build_chunk();
        int         kind;
        int         prefix_len;
        int         frames;
        int         width;
        int         cut;
        logic [7:0] marker;
        logic [7:0] b;
        logic [7:0] idx[$];
        kind   = $urandom_range(0, 9);
        marker = {3'b110, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7))};
        frames = int'(marker[2:0]) + 1;
        width  = int'(marker[4:3]) + 1;
        // Mostly short lead-ins; sometimes long enough to fill the window.
        if ($urandom_range(0, 3) == 0) prefix_len = $urandom_range(0, 40);
        else prefix_len = $urandom_range(0, 4);

        idx.push_back(marker);
        for (int i = 0; i < frames * width; i++) idx.push_back(random_byte());
        idx.push_back(marker);

        case (kind)
            6: begin
                // Opening byte differs from the closing marker in one bit.
                idx[0] = marker ^ (8'h01 << $urandom_range(0, 7));
            end
            7: begin
                // Chunk holds only the tail of the index.
                prefix_len = 0;
                cut = $urandom_range(1, idx.size() - 1);
                repeat (cut) void'(idx.pop_front());
            end
            8: begin
                // Noise, with a final byte that often looks like a marker.
                idx.delete();
                repeat ($urandom_range(0, 11)) idx.push_back(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1) != 0)
                    idx.push_back({3'b110, 5'($urandom_range(0, 31))});
                else
                    idx.push_back(8'($urandom_range(0, 255)));
            end
            9: begin
                // Final byte is never a marker.
                idx.delete();
                repeat ($urandom_range(0, 6)) idx.push_back(8'($urandom_range(0, 255)));
                do b = 8'($urandom_range(0, 255));
                while ((b & MARKER_MASK) == MARKER_TAG);
                idx.push_back(b);
            end
            default: ;
        endcase

        repeat (prefix_len) chunk_q.push_back(8'($urandom_range(0, 255)));
        foreach (idx[i]) chunk_q.push_back(idx[i]);
    endtask

    // Receiver. Outputs are sampled at the rising edge; the check and the next
    // ready value happen at the falling edge. Ready follows a pattern that
    // changes at random intervals: always ready, coin flip, a quarter duty,
    // or rarely ready. Once the stimulus asks for it, ready stays low
    // for a long stretch so the block backs up into its input side.
    initial begin
        logic                 took;
        logic [M_TDATA_W-1:0] data;
        logic [M_TUSER_W-1:0] user;
        logic                 last;
        logic                 ready;
        logic                 hold_done;
        int                   hold_left;
        int                   rx_mode;
        int                   mode_left;
        int                   phase;
        hold_done = 1'b0;
        hold_left = 0;
        rx_mode   = 0;
        mode_left = 0;
        phase     = 0;
        forever begin
            @(posedge aclk);
            took = aresetn && m_tvalid && m_tready;
            data = m_tdata;
            user = m_tuser;
            last = m_tlast;
            @(negedge aclk);
            if (took) sb.check_entry(data, user, last);
            if (hold_off_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 96);
                end
                mode_left--;
                phase++;
                case (rx_mode)
                    0:       ready = 1'b1;
                    1:       ready = $urandom_range(0, 1) != 0;
                    2:       ready = (phase % 4) == 0;
                    default: ready = $urandom_range(0, 7) == 0;
                endcase
            end
            m_tready <= ready;
        end
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("FAILURE");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed chunks. A lone zero byte and a lone all-ones byte carry no
        // marker. A lone marker is too short for its index. Then a minimal
        // valid index, one whose opening byte differs from the marker, the
        // widest size field at its largest value, and a full eight-frame index.
        chunk_q = '{8'h00};
        send_chunk();
        chunk_q = '{8'hff};
        send_chunk();
        chunk_q = '{8'hc0};
        send_chunk();
        chunk_q = '{8'hc0, 8'haa, 8'hc0};
        send_chunk();
        chunk_q = '{8'hc1, 8'h55, 8'hc0};
        send_chunk();
        chunk_q = '{8'hd8, 8'hff, 8'hff, 8'hff, 8'hff, 8'hd8};
        send_chunk();
        chunk_q = '{8'hc7, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'hc7};
        send_chunk();

        // Random chunks until the byte budget is spent; the long receiver
        // hold-off is requested as this part begins.
        hold_off_req = 1'b1;
        while (items_sent < ITEM_COUNT) begin
            build_chunk();
            send_chunk();
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sb.pending() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.flag_leftovers();
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
